// File: rtl/ath_pkg.sv
package ath_pkg;

   localparam int AXIS_W     = 16;
   localparam int ARM_W      = 14;
   localparam int PITCH_W    = 8;
   localparam int SQRT_STEPS = 32;
   localparam int ATAN_W     = 22;
   localparam int ANG_W      = 25;
   localparam int VEC_W      = 36;
   localparam int ROT_W      = 37;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   localparam logic [ARM_W-1:0]         ARM_RESET    = 14'd1850;
   localparam logic [31:0]              INV_GAIN_Q32 = 32'd2608131496;
   localparam logic signed [ANG_W-1:0]  ANG_LIMIT    = 25'sd5898240;
   localparam logic signed [ROT_W-1:0]  ROUND_HALF   = 37'sd524288;
   localparam logic signed [16:0]       RISE_MAX     = 17'sd16383;
   localparam logic signed [PITCH_W-1:0] DEG_0       = 8'sd0;
   localparam logic signed [PITCH_W-1:0] DEG_30      = 8'sd30;
   localparam logic signed [PITCH_W-1:0] DEG_45      = 8'sd45;
   localparam logic signed [PITCH_W-1:0] DEG_90      = 8'sd90;
   localparam logic signed [PITCH_W-1:0] DEG_MIN     = -8'sd90;

   typedef enum logic [1:0] {
      MAG_CORDIC,
      MAG_ZERO,
      MAG_45,
      MAG_90
   } mag_sel_type;

   typedef struct packed {
      logic              neg;
      logic [AXIS_W-1:0] ax;
      mag_sel_type       sel;
   } side_type;

   function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] idx);
      logic [ATAN_W-1:0] val;
      unique case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd4;
         5'd21:   val = 22'd2;
         5'd22:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/accel_tilt_height.sv
// Accelerometer pitch and arm rise.
// req channel: one word per sample, tdata = {accel_z, accel_y, accel_x}, x in the low bits.
// rsp channel: one word per sample, tdata = {2'b0, rise, pitch_deg}, tuser = rise_valid.
// csr port: csr_we writes csr_wdata into the arm length (hundredths of a cm).
// pitch_deg is atan(x / sqrt(y^2 + z^2)) in whole degrees, truncated toward zero.
// rise is sin(pitch) times the arm length, rounded; 0 with rise_valid low for negative pitch.
// Pipeline from req acceptance to rsp_tvalid, with one register per stage, in order:
//   input, squares, sum, 32 square-root stages, CORDIC_STEPS vectoring stages,
//   pitch, gain multiply, CORDIC_STEPS rotation stages, output register.
// Throughput: one word per cycle unless stalled; every stage is a register with a valid bit.
// Stall: while rsp_tvalid is high and rsp_tready low, the whole pipeline holds and
//   req_tready is low; nothing is dropped or repeated.
// Reset: clears all valid bits and loads the arm length with 1850 (18.5 cm).
// Write the arm length only when no sample is in flight.
module accel_tilt_height
   import ath_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // pitch_deg[7:0], rise[21:8], zero[23:22]
   output logic                  rsp_tuser,   // rise_valid[0]
   input  logic                  csr_we,
   input  logic [ARM_W-1:0]      csr_wdata
);

   logic adv;

   logic [ARM_W-1:0] arm_ff;

   logic                     in_valid_ff;
   logic signed [AXIS_W-1:0] in_x_ff, in_y_ff, in_z_ff;

   logic                     sq_valid_ff;
   logic [30:0]              ysq_ff, zsq_ff, axsq_ff;
   logic [AXIS_W-1:0]        sq_ax_ff;
   logic                     sq_neg_ff;
   logic signed [31:0]       ysq_in, zsq_in;
   logic [31:0]              axsq_in;
   logic [AXIS_W-1:0]        ax_in;

   logic                     rr_valid_ff;
   logic [31:0]              rr_ff;
   side_type                 rr_side_ff;
   logic [31:0]              rr_in;
   side_type                 rr_side_in;

   logic                     sr_valid_ff [SQRT_STEPS];
   logic [33:0]              sr_rem_ff   [SQRT_STEPS];
   logic [31:0]              sr_root_ff  [SQRT_STEPS];
   logic [31:0]              sr_rr_ff    [SQRT_STEPS];
   side_type                 sr_side_ff  [SQRT_STEPS];

   logic                     vc_valid_ff [CORDIC_STEPS];
   logic signed [VEC_W-1:0]  vc_x_ff     [CORDIC_STEPS];
   logic signed [VEC_W-1:0]  vc_y_ff     [CORDIC_STEPS];
   logic signed [ANG_W-1:0]  vc_z_ff     [CORDIC_STEPS];
   side_type                 vc_side_ff  [CORDIC_STEPS];

   logic                      pt_valid_ff;
   logic signed [PITCH_W-1:0] pt_deg_ff;
   logic signed [PITCH_W-1:0] pt_deg_in;
   logic signed [ANG_W-1:0]   vz_clamp;
   logic [6:0]                mag;

   logic                      mu_valid_ff;
   logic [33:0]               mu_x_ff;
   logic signed [PITCH_W-1:0] mu_deg_ff;
   logic [45:0]               mu_prod;

   logic                      ro_valid_ff [CORDIC_STEPS];
   logic signed [ROT_W-1:0]   ro_x_ff     [CORDIC_STEPS];
   logic signed [ROT_W-1:0]   ro_y_ff     [CORDIC_STEPS];
   logic signed [ANG_W-1:0]   ro_z_ff     [CORDIC_STEPS];
   logic signed [PITCH_W-1:0] ro_deg_ff   [CORDIC_STEPS];

   logic                      out_valid_ff;
   logic signed [PITCH_W-1:0] out_pitch_ff;
   logic [ARM_W-1:0]          out_rise_ff, out_rise_in;
   logic                      out_flag_ff, out_flag_in;
   logic signed [ROT_W-1:0]   y_rnd;
   logic signed [16:0]        r_sh;
   logic [ARM_W-1:0]          r_clamp;
   logic [ARM_W:0]            arm_inc;
   logic signed [PITCH_W-1:0] ro_deg_last;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff <= ARM_RESET;
      end else if (csr_we) begin
         arm_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_x_ff <= req_tdata[15:0];
         in_y_ff <= req_tdata[31:16];
         in_z_ff <= req_tdata[47:32];
      end
   end

   // squares
   assign ysq_in  = in_y_ff * in_y_ff;
   assign zsq_in  = in_z_ff * in_z_ff;
   assign ax_in   = in_x_ff[AXIS_W-1] ? AXIS_W'(-in_x_ff) : AXIS_W'(in_x_ff);
   assign axsq_in = 32'(ax_in) * 32'(ax_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ysq_ff    <= ysq_in[30:0];
         zsq_ff    <= zsq_in[30:0];
         axsq_ff   <= axsq_in[30:0];
         sq_ax_ff  <= ax_in;
         sq_neg_ff <= in_x_ff[AXIS_W-1];
      end
   end

   // sum of squares and special angles
   assign rr_in = 32'(ysq_ff) + 32'(zsq_ff);

   always_comb begin
      rr_side_in.neg = sq_neg_ff;
      rr_side_in.ax  = sq_ax_ff;
      priority if (rr_in == '0) begin
         rr_side_in.sel = (sq_ax_ff == '0) ? MAG_ZERO : MAG_90;
      end else if (sq_ax_ff == '0) begin
         rr_side_in.sel = MAG_ZERO;
      end else if (32'(axsq_ff) == rr_in) begin
         rr_side_in.sel = MAG_45;
      end else begin
         rr_side_in.sel = MAG_CORDIC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_valid_ff <= 1'b0;
      end else if (adv) begin
         rr_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rr_ff      <= rr_in;
         rr_side_ff <= rr_side_in;
      end
   end

   // square root of rr * 2^32, one root bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic        v_prev;
      logic [33:0] rem_prev;
      logic [31:0] root_prev;
      logic [31:0] rr_prev;
      side_type    side_prev;
      logic [1:0]  pair;
      logic [35:0] work;
      logic [35:0] trial;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      if (k == 0) begin : g_first
         assign v_prev    = rr_valid_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rr_prev   = rr_ff;
         assign side_prev = rr_side_ff;
      end else begin : g_next
         assign v_prev    = sr_valid_ff[k-1];
         assign rem_prev  = sr_rem_ff[k-1];
         assign root_prev = sr_root_ff[k-1];
         assign rr_prev   = sr_rr_ff[k-1];
         assign side_prev = sr_side_ff[k-1];
      end

      if (k < SQRT_STEPS / 2) begin : g_pair
         assign pair = rr_prev[31-2*k -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign work  = {rem_prev, pair};
      assign trial = {2'b00, root_prev, 2'b01};

      always_comb begin
         if (work >= trial) begin
            rem_in  = 34'(work - trial);
            root_in = {root_prev[30:0], 1'b1};
         end else begin
            rem_in  = work[33:0];
            root_in = {root_prev[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            sr_valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sr_rem_ff[k]  <= rem_in;
            sr_root_ff[k] <= root_in;
            sr_rr_ff[k]   <= rr_prev;
            sr_side_ff[k] <= side_prev;
         end
      end
   end

   // CORDIC vectoring on (root, |x| * 2^16)
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      logic                    v_prev;
      logic signed [VEC_W-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [ANG_W-1:0] z_prev, z_in, ang;
      side_type                side_prev;

      if (i == 0) begin : g_first
         assign v_prev    = sr_valid_ff[SQRT_STEPS-1];
         assign x_prev    = $signed({4'b0, sr_root_ff[SQRT_STEPS-1]});
         assign y_prev    = $signed({4'b0, sr_side_ff[SQRT_STEPS-1].ax, 16'b0});
         assign z_prev    = '0;
         assign side_prev = sr_side_ff[SQRT_STEPS-1];
      end else begin : g_next
         assign v_prev    = vc_valid_ff[i-1];
         assign x_prev    = vc_x_ff[i-1];
         assign y_prev    = vc_y_ff[i-1];
         assign z_prev    = vc_z_ff[i-1];
         assign side_prev = vc_side_ff[i-1];
      end

      assign ang = $signed({3'b0, atan_q16(5'(i))});

      always_comb begin
         if (!y_prev[VEC_W-1] && (y_prev != '0)) begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + ang;
         end else begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vc_valid_ff[i] <= 1'b0;
         end else if (adv) begin
            vc_valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            vc_x_ff[i]    <= x_in;
            vc_y_ff[i]    <= y_in;
            vc_z_ff[i]    <= z_in;
            vc_side_ff[i] <= side_prev;
         end
      end
   end

   // clamp angle, pick special cases, apply sign
   always_comb begin
      priority if (vc_z_ff[CORDIC_STEPS-1] < 0) begin
         vz_clamp = '0;
      end else if (vc_z_ff[CORDIC_STEPS-1] > ANG_LIMIT) begin
         vz_clamp = ANG_LIMIT;
      end else begin
         vz_clamp = vc_z_ff[CORDIC_STEPS-1];
      end
      unique case (vc_side_ff[CORDIC_STEPS-1].sel)
         MAG_ZERO: mag = 7'(DEG_0);
         MAG_45:   mag = 7'(DEG_45);
         MAG_90:   mag = 7'(DEG_90);
         default:  mag = vz_clamp[22:16];
      endcase
      pt_deg_in = vc_side_ff[CORDIC_STEPS-1].neg ? -$signed({1'b0, mag})
                                                  : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= 1'b0;
      end else if (adv) begin
         pt_valid_ff <= vc_valid_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_deg_ff <= pt_deg_in;
      end
   end

   // arm length over CORDIC gain
   assign mu_prod = 46'(arm_ff) * 46'(INV_GAIN_Q32);

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_valid_ff <= 1'b0;
      end else if (adv) begin
         mu_valid_ff <= pt_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mu_x_ff   <= mu_prod[45:12];
         mu_deg_ff <= pt_deg_ff;
      end
   end

   // CORDIC rotation by the pitch
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic                      v_prev;
      logic signed [ROT_W-1:0]   x_prev, y_prev, x_in, y_in;
      logic signed [ANG_W-1:0]   z_prev, z_in, ang;
      logic signed [PITCH_W-1:0] deg_prev;

      if (i == 0) begin : g_first
         assign v_prev   = mu_valid_ff;
         assign x_prev   = $signed({3'b0, mu_x_ff});
         assign y_prev   = '0;
         assign z_prev   = $signed({mu_deg_ff[PITCH_W-1], mu_deg_ff, 16'b0});
         assign deg_prev = mu_deg_ff;
      end else begin : g_next
         assign v_prev   = ro_valid_ff[i-1];
         assign x_prev   = ro_x_ff[i-1];
         assign y_prev   = ro_y_ff[i-1];
         assign z_prev   = ro_z_ff[i-1];
         assign deg_prev = ro_deg_ff[i-1];
      end

      assign ang = $signed({3'b0, atan_q16(5'(i))});

      always_comb begin
         if (!z_prev[ANG_W-1]) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - ang;
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ro_valid_ff[i] <= 1'b0;
         end else if (adv) begin
            ro_valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ro_x_ff[i]   <= x_in;
            ro_y_ff[i]   <= y_in;
            ro_z_ff[i]   <= z_in;
            ro_deg_ff[i] <= deg_prev;
         end
      end
   end

   // round, clamp, exact sines
   assign ro_deg_last = ro_deg_ff[CORDIC_STEPS-1];
   assign y_rnd       = ro_y_ff[CORDIC_STEPS-1] + ROUND_HALF;
   assign r_sh        = 17'(y_rnd >>> 20);
   assign arm_inc     = {1'b0, arm_ff} + 15'd1;

   always_comb begin
      priority if (r_sh < 0) begin
         r_clamp = '0;
      end else if (r_sh > RISE_MAX) begin
         r_clamp = RISE_MAX[ARM_W-1:0];
      end else begin
         r_clamp = r_sh[ARM_W-1:0];
      end
      out_flag_in = 1'b1;
      priority if (ro_deg_last < 0) begin
         out_rise_in = '0;
         out_flag_in = 1'b0;
      end else if (ro_deg_last == DEG_0) begin
         out_rise_in = '0;
      end else if (ro_deg_last == DEG_90) begin
         out_rise_in = arm_ff;
      end else if (ro_deg_last == DEG_30) begin
         out_rise_in = arm_inc[ARM_W:1];
      end else begin
         out_rise_in = r_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= ro_valid_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pitch_ff <= ro_deg_last;
         out_rise_ff  <= out_rise_in;
         out_flag_ff  <= out_flag_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_rise_ff, out_pitch_ff};
   assign rsp_tuser  = out_flag_ff;

`ifndef SYNTHESIS
   a_flag_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == !out_pitch_ff[PITCH_W-1]))
      else $error("rise_valid disagrees with pitch sign");

   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (out_rise_ff == '0))
      else $error("rise nonzero for negative pitch");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_pitch_ff >= DEG_MIN && out_pitch_ff <= DEG_90))
      else $error("pitch out of range");

   a_full_rise: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_pitch_ff == DEG_90) |-> (out_rise_ff == arm_ff))
      else $error("rise at 90 degrees differs from arm length");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv && pt_valid_ff) |=> pt_valid_ff && $stable(pt_deg_ff))
      else $error("pipeline moved during stall");
`endif

endmodule
